// ===== rtl/core/clcg_pkg.sv =====
// shared types, constants and corner tables of the cubic lattice connectivity generator
`timescale 1ns / 1ps
`default_nettype none

package clcg_pkg;

  localparam int DEFAULT_MAX_SIZE = 64;

  localparam int SIZE_W     = 7;
  localparam int POS_W      = 6;
  localparam int HALF_W     = 7;
  localparam int ID_W       = 20;
  localparam int KIND_W     = 2;
  localparam int PLANE_W    = 2 * SIZE_W;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // register index, taken from paddr[3:2]
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 2'd3;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_CELL  = 1'b1;

  localparam logic REC_NODE = 1'b0;
  localparam logic REC_EDGE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    LK_SIMPLE = 2'd0,
    LK_BODY   = 2'd1,
    LK_FACE   = 2'd2
  } lattice_kind_t;

  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] pos_i;
    logic [POS_W-1:0] pos_j;
    logic [POS_W-1:0] pos_k;
    logic             restart;
  } cmd_t;

  typedef struct packed {
    logic              record_kind;
    logic [ID_W-1:0]   node_id;
    logic [ID_W-1:0]   partner_id;
    logic [HALF_W-1:0] half_x;
    logic [HALF_W-1:0] half_y;
    logic [HALF_W-1:0] half_z;
    logic              last;
  } res_t;

  // operands of the shared multiply-add unit
  typedef struct packed {
    logic [PLANE_W-1:0] a;
    logic [SIZE_W-1:0]  b;
    logic [ID_W-1:0]    addend;
  } mac_op_t;

  // corner code of an fcc face edge: bit0 adds 1, bit1 adds size_x, bit2 adds the plane
  function automatic logic [2:0] fcc_corner(input logic [2:0] face, input logic [1:0] n);
    logic [2:0] lo;
    logic [2:0] hi;
    lo = 3'b000;
    hi = 3'b000;
    case (face[2:1])
      2'd0: begin
        hi = 3'b001;
        case (n)
          2'd0:    lo = 3'b000;
          2'd1:    lo = 3'b100;
          2'd2:    lo = 3'b110;
          default: lo = 3'b010;
        endcase
      end
      2'd1: begin
        hi = 3'b010;
        case (n)
          2'd0:    lo = 3'b000;
          2'd1:    lo = 3'b001;
          2'd2:    lo = 3'b100;
          default: lo = 3'b101;
        endcase
      end
      default: begin
        hi = 3'b100;
        lo = {1'b0, n};
      end
    endcase
    return face[0] ? (lo | hi) : lo;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clcg_mac.sv =====
// shared multiply-add unit for the lattice index arithmetic
`timescale 1ns / 1ps
`default_nettype none

module clcg_mac import clcg_pkg::*; (
  input  mac_op_t         op,
  output logic [ID_W-1:0] sum
);

  logic [PLANE_W+SIZE_W-1:0] prod;

  assign prod = op.a * op.b;
  // ids wrap modulo 2^20
  assign sum  = op.addend + prod[ID_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/cubic_lattice_connectivity_gen_unit.sv =====
// cubic lattice connectivity generator: sequencer, record builder and register port
// after a transfer the multiply-add states plane, base, row and offset run, then the record steps
// (point pass 4 steps, bcc cell 9, fcc cell 5 per present face and 1 per absent one)
// cmd_stall is high from a transfer until the last step is issued or the item yields no
// record, so no new item is taken before then; one record step a cycle when res_stall stays low
// reset: synchronous rst clears the sequencer, output valid, extra node counter and
// the configuration registers (sizes 2, simple cubic)
`timescale 1ns / 1ps
`default_nettype none

module cubic_lattice_connectivity_gen_unit import clcg_pkg::*; #(
  parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // item channel
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  // record channel
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res
);

  // size registers are 7 bits, so the saturation bound never exceeds 127
  localparam int SIZE_CAP_INT = (MAX_SIZE > (1 << SIZE_W) - 1) ? (1 << SIZE_W) - 1 : MAX_SIZE;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SIZE_CAP_INT);

  localparam logic [3:0] PT_LAST_REC   = 4'd3;
  localparam logic [3:0] BCC_LAST_REC  = 4'd8;
  localparam logic [3:0] FCC_LAST_REC  = 4'd4;
  localparam logic [2:0] FCC_LAST_FACE = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PLANE = 6'b000010,
    ST_BASE  = 6'b000100,
    ST_ROW   = 6'b001000,
    ST_OFF   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] r);
    if (r < SIZE_W'(2)) return SIZE_W'(2);
    if (r > SIZE_CAP) return SIZE_CAP;
    return r;
  endfunction

  // coordinate in half-cell units: lattice plane (2n, +2 on the far face) or cell middle
  function automatic logic [HALF_W-1:0] half_pos(input logic [POS_W-1:0] idx,
                                                 input logic on_plane, input logic far);
    if (on_plane) return {idx, 1'b0} + {{(HALF_W-2){1'b0}}, far, 1'b0};
    return {idx, 1'b1};
  endfunction

  // configuration registers
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [KIND_W-1:0] lattice_kind;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x       <= SIZE_W'(2);
      size_y       <= SIZE_W'(2);
      size_z       <= SIZE_W'(2);
      lattice_kind <= LK_SIMPLE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x       <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_y       <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_z       <= pwdata[SIZE_W-1:0];
        REG_KIND:   lattice_kind <= pwdata[KIND_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = {{(CFG_DATA_W-SIZE_W){1'b0}}, size_x};
      REG_SIZE_Y: prdata = {{(CFG_DATA_W-SIZE_W){1'b0}}, size_y};
      REG_SIZE_Z: prdata = {{(CFG_DATA_W-SIZE_W){1'b0}}, size_z};
      REG_KIND:   prdata = {{(CFG_DATA_W-KIND_W){1'b0}}, lattice_kind};
      default:    prdata = '0;
    endcase
  end

  // saturated sizes; registers should change only while idle, which the block does not enforce
  logic [SIZE_W-1:0] sx, sy, sz;
  assign sx = clamp_size(size_x);
  assign sy = clamp_size(size_y);
  assign sz = clamp_size(size_z);

  // sequencer and item registers
  state_t             state;
  logic               op_r;
  logic [POS_W-1:0]   i_r, j_r, k_r;
  logic [PLANE_W-1:0] plane;
  logic [ID_W-1:0]    base;
  logic [ID_W-1:0]    off;
  logic [2:0]         grp;
  logic [3:0]         rec;
  logic [ID_W-1:0]    extra_count;
  logic               cmd_acc;

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;

  // shared multiply-add: plane, base, row offset, then full offset
  mac_op_t         mac_op;
  logic [ID_W-1:0] mac_sum;

  clcg_mac u_mac (
    .op  (mac_op),
    .sum (mac_sum)
  );

  always_comb begin
    mac_op = '0;
    case (state)
      ST_PLANE: begin
        mac_op.a = {{(PLANE_W-SIZE_W){1'b0}}, sx};
        mac_op.b = sy;
      end
      ST_BASE: begin
        mac_op.a = plane;
        mac_op.b = sz;
      end
      ST_ROW: begin
        mac_op.a      = {{(PLANE_W-POS_W){1'b0}}, j_r};
        mac_op.b      = sx;
        mac_op.addend = {{(ID_W-POS_W){1'b0}}, i_r};
      end
      ST_OFF: begin
        mac_op.a      = plane;
        mac_op.b      = {{(SIZE_W-POS_W){1'b0}}, k_r};
        mac_op.addend = off;
      end
      default: mac_op = '0;
    endcase
  end

  // does this item yield any record
  logic kind_ok, pt_in, cell_in, item_ok;
  assign kind_ok = (lattice_kind == LK_SIMPLE) || (lattice_kind == LK_BODY) ||
                   (lattice_kind == LK_FACE);
  assign pt_in   = ({1'b0, i_r} < sx) && ({1'b0, j_r} < sy) && ({1'b0, k_r} < sz);
  assign cell_in = ({1'b0, i_r} < sx - SIZE_W'(1)) && ({1'b0, j_r} < sy - SIZE_W'(1)) &&
                   ({1'b0, k_r} < sz - SIZE_W'(1));
  assign item_ok = kind_ok && ((op_r == OP_POINT) ? pt_in :
                               ((lattice_kind != LK_SIMPLE) && cell_in));

  // step enables: point node and forward edges, fcc faces (far faces on the boundary only)
  logic [3:0] en_pt;
  logic [5:0] face_en;
  assign en_pt   = {({1'b0, k_r} < sz - SIZE_W'(1)), ({1'b0, j_r} < sy - SIZE_W'(1)),
                    ({1'b0, i_r} < sx - SIZE_W'(1)), 1'b1};
  assign face_en = {({1'b0, k_r} == sz - SIZE_W'(2)), 1'b1,
                    ({1'b0, j_r} == sy - SIZE_W'(2)), 1'b1,
                    ({1'b0, i_r} == sx - SIZE_W'(2)), 1'b1};

  // per-step decode
  logic       step_en, step_last, step_final, step_bump;
  logic [2:0] code;
  logic       is_node;

  always_comb begin
    step_en    = 1'b0;
    step_last  = 1'b0;
    step_final = 1'b0;
    step_bump  = 1'b0;
    code       = 3'b000;
    is_node    = (rec == 4'd0);
    if (op_r == OP_POINT) begin
      step_en    = en_pt[rec[1:0]];
      step_last  = ((en_pt >> rec[1:0]) >> 1) == 4'd0;
      step_final = (rec == PT_LAST_REC);
      case (rec[1:0])
        2'd1:    code = 3'b001;
        2'd2:    code = 3'b010;
        default: code = 3'b100;
      endcase
    end else if (lattice_kind == LK_BODY) begin
      // centre node, then corners in offset order
      step_en    = 1'b1;
      step_final = (rec == BCC_LAST_REC);
      step_last  = step_final;
      step_bump  = step_final;
      code       = rec[2:0] - 3'd1;
    end else begin
      step_en    = face_en[grp];
      step_final = (!face_en[grp] || rec == FCC_LAST_REC) && (grp == FCC_LAST_FACE);
      step_last  = (rec == FCC_LAST_REC) && (((face_en >> grp) >> 1) == 6'd0);
      step_bump  = face_en[grp] && (rec == FCC_LAST_REC);
      code       = fcc_corner(grp, rec[1:0] - 2'd1);
    end
  end

  // record fields
  logic [PLANE_W:0]    corner_ofs;
  logic [ID_W-1:0]     partner, ext_id, id_cur;
  logic [HALF_W-1:0]   hx, hy, hz;
  res_t                rec_new;

  assign corner_ofs = (code[0] ? (PLANE_W+1)'(1) : '0) +
                      (code[1] ? {{(PLANE_W+1-SIZE_W){1'b0}}, sx} : '0) +
                      (code[2] ? {1'b0, plane} : '0);
  assign partner = off + {{(ID_W-PLANE_W-1){1'b0}}, corner_ofs};
  assign ext_id  = base + extra_count;
  assign id_cur  = (op_r == OP_POINT) ? off : ext_id;

  always_comb begin
    if (op_r == OP_POINT) begin
      hx = half_pos(i_r, 1'b1, 1'b0);
      hy = half_pos(j_r, 1'b1, 1'b0);
      hz = half_pos(k_r, 1'b1, 1'b0);
    end else if (lattice_kind == LK_BODY) begin
      hx = half_pos(i_r, 1'b0, 1'b0);
      hy = half_pos(j_r, 1'b0, 1'b0);
      hz = half_pos(k_r, 1'b0, 1'b0);
    end else begin
      // face normal axis sits on a lattice plane
      hx = half_pos(i_r, grp[2:1] == 2'd0, grp[0]);
      hy = half_pos(j_r, grp[2:1] == 2'd1, grp[0]);
      hz = half_pos(k_r, grp[2:1] == 2'd2, grp[0]);
    end
  end

  always_comb begin
    rec_new             = '0;
    rec_new.node_id     = id_cur;
    rec_new.last        = step_last;
    if (is_node) begin
      rec_new.record_kind = REC_NODE;
      rec_new.half_x      = hx;
      rec_new.half_y      = hy;
      rec_new.half_z      = hz;
    end else begin
      rec_new.record_kind = REC_EDGE;
      rec_new.partner_id  = partner;
    end
  end

  // output register holds a record under res_stall; the builder waits while it is full and stalled
  logic slot_free, emit_go;
  assign slot_free = !res_valid || !res_stall;
  assign emit_go   = (state == ST_EMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_go && step_en) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go && step_en) begin
      res <= rec_new;
    end
  end

  // extra node counter
  always_ff @(posedge clk) begin
    if (rst) begin
      extra_count <= '0;
    end else if (cmd_acc && cmd.restart) begin
      extra_count <= '0;
    end else if (emit_go && step_bump) begin
      extra_count <= extra_count + ID_W'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:  if (cmd_acc) state <= ST_PLANE;
        ST_PLANE: state <= ST_BASE;
        ST_BASE:  state <= ST_ROW;
        ST_ROW:   state <= ST_OFF;
        ST_OFF:   state <= item_ok ? ST_EMIT : ST_IDLE;
        ST_EMIT:  if (emit_go && step_final) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // item fields, products and step counters
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      op_r <= cmd.operation;
      i_r  <= cmd.pos_i;
      j_r  <= cmd.pos_j;
      k_r  <= cmd.pos_k;
    end
    if (state == ST_PLANE) plane <= mac_sum[PLANE_W-1:0];
    if (state == ST_BASE)  base  <= mac_sum;
    if (state == ST_ROW || state == ST_OFF) off <= mac_sum;
    if (state == ST_OFF) begin
      grp <= 3'd0;
      rec <= 4'd0;
    end else if (emit_go) begin
      if (op_r == OP_CELL && lattice_kind == LK_FACE &&
          (!face_en[grp] || rec == FCC_LAST_REC)) begin
        grp <= grp + 3'd1;
        rec <= 4'd0;
      end else begin
        rec <= rec + 4'd1;
      end
    end
  end

`ifndef SYNTHESIS
  // outside record emission any held record closes its item
  a_held_is_last: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EMIT && res_valid) |-> res.last)
    else $error("pending record outside emission without last");

  // counter moves only on a restart transfer or while records are built
  a_count_source: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && extra_count != $past(extra_count)) |->
      ($past(state) == ST_EMIT || $past(cmd_acc)))
    else $error("extra node counter changed outside emission");

  // node records carry no partner
  a_node_partner: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.record_kind == REC_NODE) |-> (res.partner_id == '0))
    else $error("node record with nonzero partner");

  // a simple cubic lattice never reaches the cell emission
  a_simple_cell: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && op_r == OP_CELL) |-> (lattice_kind != LK_SIMPLE))
    else $error("cell pass emitting on a simple cubic lattice");
`endif

endmodule

`default_nettype wire
